### src/acd_pkg.sv
// Shared constants and types for the age counter cache directory.
package acd_pkg;

    localparam int ENTRIES  = 10;
    localparam int KEY_BITS = 64;
    localparam int KEY_W    = 64;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W    = 14;
    localparam int SLOT_W   = 4;

    localparam logic [AGE_W-1:0] FRESH_AGE = AGE_W'(9999);

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Token that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic             active;
        logic             op;
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [AGE_W-1:0] best_age;
        logic [IDX_W-1:0] best_idx;
    } scan_t;

    // Insert commit broadcast to every cell.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] victim;
    } upd_t;

endpackage

### src/acd_cell.sv
// One directory slot: valid, key and age, plus its stage of the scan chain.
module acd_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [acd_pkg::IDX_W-1:0]     cell_idx,
    input  logic [acd_pkg::KEY_BITS-1:0]  req_key,
    input  acd_pkg::scan_t                scan_in,
    output acd_pkg::scan_t                scan_out,
    input  acd_pkg::upd_t                 upd
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [acd_pkg::AGE_W-1:0]     age_reg;
    logic [acd_pkg::AGE_W-1:0]     age_next;
    logic [acd_pkg::KEY_BITS-1:0]  key_reg;
    logic                          key_we;
    acd_pkg::scan_t                scan_reg;
    acd_pkg::scan_t                scan_next;
    logic                          is_victim;

    // scan stage: lookups take the first match, inserts the first empty slot,
    // otherwise track the smallest age below the fresh value
    always_comb
    begin
        scan_next = scan_in;
        if (scan_in.active)
        begin
            if (scan_in.op == acd_pkg::OP_LOOKUP)
            begin
                if (!scan_in.found && valid_reg && (key_reg == req_key))
                begin
                    scan_next.found = 1'b1;
                    scan_next.idx   = cell_idx;
                end
            end
            else if (!scan_in.found)
            begin
                if (!valid_reg)
                begin
                    scan_next.found = 1'b1;
                    scan_next.idx   = cell_idx;
                end
                else if (age_reg < scan_in.best_age)
                begin
                    scan_next.best_age = age_reg;
                    scan_next.best_idx = cell_idx;
                end
            end
        end
    end

    assign is_victim = upd.en && (upd.victim == cell_idx);
    assign key_we    = is_victim;

    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        if (is_victim)
        begin
            valid_next = 1'b1;
            age_next   = acd_pkg::FRESH_AGE;
        end
        else if (upd.en && valid_reg && (age_reg != '0))
        begin
            age_next = age_reg - acd_pkg::AGE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_reg <= req_key;
        end
    end

    assign scan_out = scan_reg;

endmodule

### src/age_counter_cache_directory.sv
// Age counter cache directory: row of slot cells with a walking scan token.
// Requests run one at a time: a new one is taken only after the token of the last one has left
// the cell row and while no finished result is held in the pending register.
// A finished result may wait in the output register while the next request runs.
// Reset (rst_n, async low) empties all slots and zeroes all ages; keys are not cleared.
module age_counter_cache_directory (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       operation,
    input  logic [acd_pkg::KEY_W-1:0]  key,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       hit,
    output logic [acd_pkg::SLOT_W-1:0] slot,
    output logic                       replaced
);

    localparam int N = acd_pkg::ENTRIES;

    logic                          busy_reg;
    logic                          busy_next;
    logic                          start_reg;
    logic                          op_reg;
    logic [acd_pkg::KEY_BITS-1:0]  key_reg;
    logic                          accept;

    acd_pkg::scan_t                scan_link [N+1];
    acd_pkg::scan_t                fin;
    acd_pkg::upd_t                 upd;

    logic                          res_hit;
    logic [acd_pkg::SLOT_W-1:0]    res_slot;
    logic                          res_replaced;
    logic [acd_pkg::IDX_W-1:0]     victim;

    logic                          pend_valid_reg;
    logic                          pend_valid_next;
    logic                          pend_hit_reg;
    logic [acd_pkg::SLOT_W-1:0]    pend_slot_reg;
    logic                          pend_replaced_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_hit_reg;
    logic [acd_pkg::SLOT_W-1:0]    out_slot_reg;
    logic                          out_replaced_reg;
    logic                          out_free;
    logic                          load_out_pend;
    logic                          load_out_fin;
    logic                          load_pend;

    assign in_ready = !busy_reg && !pend_valid_reg;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            key_reg <= key[acd_pkg::KEY_BITS-1:0];
        end
    end

    // token enters cell 0 in the cycle after accept, once the request is latched
    always_comb
    begin
        scan_link[0]          = '0;
        scan_link[0].active   = start_reg;
        scan_link[0].op       = op_reg;
        scan_link[0].best_age = acd_pkg::FRESH_AGE;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        acd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (acd_pkg::IDX_W'(i)),
            .req_key  (key_reg),
            .scan_in  (scan_link[i]),
            .scan_out (scan_link[i+1]),
            .upd      (upd)
        );
    end

    assign fin = scan_link[N];

    // full directory: every slot valid, best_idx is slot 0 if none below fresh age
    always_comb
    begin
        victim       = fin.found ? fin.idx : fin.best_idx;
        upd.en       = fin.active && (fin.op == acd_pkg::OP_INSERT);
        upd.victim   = victim;
        if (fin.op == acd_pkg::OP_INSERT)
        begin
            res_hit      = 1'b0;
            res_slot     = acd_pkg::SLOT_W'(victim);
            res_replaced = !fin.found;
        end
        else
        begin
            res_hit      = fin.found;
            res_slot     = fin.found ? acd_pkg::SLOT_W'(fin.idx) : '0;
            res_replaced = 1'b0;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (fin.active)
        begin
            busy_next = 1'b0;
        end
    end

    assign out_free      = !out_valid_reg || out_ready;
    assign load_out_pend = pend_valid_reg && out_free;
    assign load_out_fin  = fin.active && out_free && !pend_valid_reg;
    assign load_pend     = fin.active && !load_out_fin;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (load_pend)
        begin
            pend_valid_next = 1'b1;
        end
        else if (load_out_pend)
        begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (load_out_pend || load_out_fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            start_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            start_reg      <= accept;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_pend)
        begin
            pend_hit_reg      <= res_hit;
            pend_slot_reg     <= res_slot;
            pend_replaced_reg <= res_replaced;
        end
        if (load_out_pend)
        begin
            out_hit_reg      <= pend_hit_reg;
            out_slot_reg     <= pend_slot_reg;
            out_replaced_reg <= pend_replaced_reg;
        end
        else if (load_out_fin)
        begin
            out_hit_reg      <= res_hit;
            out_slot_reg     <= res_slot;
            out_replaced_reg <= res_replaced;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign slot      = out_slot_reg;
    assign replaced  = out_replaced_reg;

endmodule

### tb/acd_checker.sv
// Checker for the cache directory: tracks slots, predicts each result and compares.
module acd_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       operation,
    input  logic [acd_pkg::KEY_W-1:0]  key,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       hit,
    input  logic [acd_pkg::SLOT_W-1:0] slot,
    input  logic                       replaced,
    output int                         fail_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                       hit;
        logic [acd_pkg::SLOT_W-1:0] slot;
        logic                       replaced;
    } dir_result_t;

    logic                         dir_valid [acd_pkg::ENTRIES];
    logic [acd_pkg::KEY_BITS-1:0] dir_key   [acd_pkg::ENTRIES];
    logic [acd_pkg::AGE_W-1:0]    dir_age   [acd_pkg::ENTRIES];

    dir_result_t expected_results [$];

    initial fail_count = 0;

    task automatic note_failure(input string what, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp_v, act_v);
        fail_count++;
    endtask

    // Advances the directory state by one request and returns its result.
    function automatic dir_result_t apply_request(input logic op,
                                                  input logic [acd_pkg::KEY_W-1:0] k);
        dir_result_t               r;
        logic [acd_pkg::AGE_W-1:0] best;
        int                        victim;
        bit                        found_empty;
        r = '0;
        if (op == acd_pkg::OP_LOOKUP)
        begin
            // lowest matching slot wins when a key was inserted twice
            for (int i = acd_pkg::ENTRIES - 1; i >= 0; i--)
            begin
                if (dir_valid[i] && dir_key[i] == k[acd_pkg::KEY_BITS-1:0])
                begin
                    r.hit  = 1'b1;
                    r.slot = acd_pkg::SLOT_W'(i);
                end
            end
            return r;
        end
        best        = acd_pkg::FRESH_AGE;
        victim      = 0;
        found_empty = 1'b0;
        for (int i = 0; i < acd_pkg::ENTRIES; i++)
        begin
            if (!found_empty)
            begin
                if (!dir_valid[i])
                begin
                    victim      = i;
                    found_empty = 1'b1;
                end
                else if (dir_age[i] < best)
                begin
                    best   = dir_age[i];
                    victim = i;
                end
            end
        end
        r.slot     = acd_pkg::SLOT_W'(victim);
        r.replaced = dir_valid[victim];
        dir_valid[victim] = 1'b1;
        dir_key[victim]   = k[acd_pkg::KEY_BITS-1:0];
        dir_age[victim]   = acd_pkg::FRESH_AGE;
        for (int i = 0; i < acd_pkg::ENTRIES; i++)
        begin
            if (i != victim && dir_valid[i] && dir_age[i] != '0)
                dir_age[i] = dir_age[i] - 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dir_result_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < acd_pkg::ENTRIES; i++)
            begin
                dir_valid[i] = 1'b0;
                dir_key[i]   = '0;
                dir_age[i]   = '0;
            end
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: extra result: expected none, actual %0b/%0d/%0b",
                             $time, hit, slot, replaced);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (hit !== exp_r.hit)
                        note_failure("hit", 64'(exp_r.hit), 64'(hit));
                    if (slot !== exp_r.slot)
                        note_failure("slot", 64'(exp_r.slot), 64'(slot));
                    if (replaced !== exp_r.replaced)
                        note_failure("replaced", 64'(exp_r.replaced), 64'(replaced));
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_request(operation, key));
        end
        pending = expected_results.size();
    end

endmodule

### tb/tb_age_counter_cache_directory.sv
// Top of the cache directory testbench: reset, request stimulus, result stalls, verdict.
module tb_age_counter_cache_directory;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SIZE    = 16;
    localparam int RANDOM_COUNT = 800;
    localparam int DRAIN_CYCLES = 4 * (acd_pkg::ENTRIES + 2);

    // receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_RUNS   = 2;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       operation = acd_pkg::OP_LOOKUP;
    logic [acd_pkg::KEY_W-1:0]  key       = '0;
    logic                       out_ready = 1'b0;
    logic                       in_ready;
    logic                       out_valid;
    logic                       hit;
    logic [acd_pkg::SLOT_W-1:0] slot;
    logic                       replaced;
    int                         fail_count;
    int                         pending;

    int                         burst_left = 0;
    logic [acd_pkg::KEY_W-1:0]  key_pool [POOL_SIZE];

    age_counter_cache_directory DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .slot      (slot),
        .replaced  (replaced)
    );

    acd_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .key        (key),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .slot       (slot),
        .replaced   (replaced),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    // Result side: switches between randomly chosen stall patterns at random intervals.
    int   rx_mode      = RX_OPEN;
    int   rx_mode_left = 0;
    int   rx_run_left  = 0;
    logic rx_run_level = 1'b1;

    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode_left = $urandom_range(100, 400);
            rx_mode      = $urandom_range(RX_OPEN, RX_RUNS);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (rx_run_left == 0)
                begin
                    rx_run_left  = $urandom_range(1, 40);
                    rx_run_level = ~rx_run_level;
                end
                rx_run_left--;
                out_ready <= rx_run_level;
            end
        endcase
    end

    // Sends one request; requests go out in bursts separated by random gaps.
    task automatic issue_request(input logic op, input logic [acd_pkg::KEY_W-1:0] k);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        operation <= op;
        key       <= k;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [acd_pkg::KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        logic [acd_pkg::KEY_W-1:0] k;
        logic                      op;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty directory misses, then two inserts and their hits
        issue_request(acd_pkg::OP_LOOKUP, '0);
        issue_request(acd_pkg::OP_LOOKUP, '1);
        issue_request(acd_pkg::OP_INSERT, '0);
        issue_request(acd_pkg::OP_INSERT, '1);
        issue_request(acd_pkg::OP_LOOKUP, '0);
        issue_request(acd_pkg::OP_LOOKUP, '1);
        // same key stored twice: lookup reports the lower slot
        issue_request(acd_pkg::OP_INSERT, '1);
        issue_request(acd_pkg::OP_LOOKUP, '1);
        for (int i = 0; i < acd_pkg::ENTRIES - 3; i++)
            issue_request(acd_pkg::OP_INSERT, {32'hA5A5_5A5A, 32'(i)});
        // full: oldest slots get replaced in insertion order
        issue_request(acd_pkg::OP_INSERT, 64'h0123_4567_89AB_CDEF);
        issue_request(acd_pkg::OP_LOOKUP, '0);
        issue_request(acd_pkg::OP_LOOKUP, '1);
        issue_request(acd_pkg::OP_INSERT, 64'hFEDC_BA98_7654_3210);
        issue_request(acd_pkg::OP_LOOKUP, '1);
        issue_request(acd_pkg::OP_LOOKUP, 64'h0123_4567_89AB_CDEF);

        // small key pool keeps hits and replacements frequent
        foreach (key_pool[i])
            key_pool[i] = random_key();
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if ($urandom_range(0, 49) == 0)
                key_pool[$urandom_range(0, POOL_SIZE - 1)] = random_key();
            if ($urandom_range(0, 4) == 0)
                k = random_key();
            else
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            op = ($urandom_range(0, 99) < 35) ? acd_pkg::OP_INSERT : acd_pkg::OP_LOOKUP;
            issue_request(op, k);
        end
        in_valid <= 1'b0;

        // let the checker count the last request before pending is read
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
